### rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

   // Default sizes
   localparam int MAX_TASKS_DEF = 256;
   localparam int NUM_CPUS_DEF  = 8;

   // Field widths of the channels
   localparam int OP_W   = 3;
   localparam int CPU_FW = 3;
   localparam int TASK_W = 8;
   localparam int CODE_W = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
   localparam logic [OP_W-1:0] OP_SAVE   = 3'd1;
   localparam logic [OP_W-1:0] OP_SCHED  = 3'd2;
   localparam logic [OP_W-1:0] OP_BLOCK  = 3'd3;
   localparam logic [OP_W-1:0] OP_WAKE   = 3'd4;

   // Result codes
   localparam logic [CODE_W-1:0] RES_OK      = 2'd0;
   localparam logic [CODE_W-1:0] RES_FULL    = 2'd1;
   localparam logic [CODE_W-1:0] RES_NO_TASK = 2'd2;

   // Task states held in the table
   localparam logic [1:0] ST_RUNNABLE = 2'd0;
   localparam logic [1:0] ST_RUNNING  = 2'd1;
   localparam logic [1:0] ST_BLOCKED  = 2'd2;

   // Table read address sources
   localparam logic [1:0] RD_CUR       = 2'd0;
   localparam logic [1:0] RD_REQ       = 2'd1;
   localparam logic [1:0] RD_NEXT_CUR  = 2'd2;
   localparam logic [1:0] RD_NEXT_SCAN = 2'd3;

   // Table write address sources
   localparam logic [1:0] WR_COUNT = 2'd0;
   localparam logic [1:0] WR_CUR   = 2'd1;
   localparam logic [1:0] WR_REQ   = 2'd2;
   localparam logic [1:0] WR_SCAN  = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              load;
      logic              rd_en;
      logic [1:0]        rd_src;
      logic              wr_en;
      logic [1:0]        wr_dst;
      logic [1:0]        wr_val;
      logic              cnt_inc;
      logic              scan_init;
      logic              scan_step;
      logic              cur_hit;
      logic              cur_idle;
      logic              res_code_en;
      logic [CODE_W-1:0] res_code;
      logic              res_tid_count;
      logic              res_tid_scan;
      logic              res_idle;
      logic              rsp_load;
   } rrts_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            cpu_ok;
      logic            cur_live;
      logic            full;
      logic            req_oob;
      logic            count_zero;
      logic            scan_last;
      logic [1:0]      rd_state;
      logic            rsp_busy;
   } rrts_status_type;

endpackage

### rtl/rrts_if.sv
// Request and response channel interfaces of the task scheduler.
`timescale 1ns / 1ps

interface rrts_req_if import rrts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CPU_FW-1:0] cpu;
   logic [TASK_W-1:0] task_req;

   modport source (output valid, output op, output cpu, output task_req, input ready);
   modport sink   (input valid, input op, input cpu, input task_req, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] result_code;
   logic [TASK_W-1:0] task_id;
   logic              idle_chosen;

   modport source (output valid, output result_code, output task_id, output idle_chosen,
                   input ready);
   modport sink   (input valid, input result_code, input task_id, input idle_chosen,
                   output ready);
endinterface

### rtl/rrts_datapath.sv
// Datapath of the task scheduler: task table, per-CPU current task, scan pointer, result.
`timescale 1ns / 1ps

module rrts_datapath import rrts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int NUM_CPUS  = NUM_CPUS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rrts_cmd_type      cmd,
   output rrts_status_type   status,
   input  logic [OP_W-1:0]   req_op,
   input  logic [CPU_FW-1:0] req_cpu,
   input  logic [TASK_W-1:0] req_task_req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CODE_W-1:0] rsp_result_code,
   output logic [TASK_W-1:0] rsp_task_id,
   output logic              rsp_idle_chosen
);

   localparam int TW    = $clog2(MAX_TASKS);
   localparam int CW    = $clog2(MAX_TASKS + 1);
   localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int CMP_W = (CW > TASK_W) ? CW : TASK_W;

   // Latched item
   logic [OP_W-1:0]   op_ff;
   logic [CPU_FW-1:0] cpu_ff;
   logic [TASK_W-1:0] treq_ff;

   // Scheduler state
   logic [CW-1:0]     count_ff;
   logic [TW-1:0]     cur_idx_ff  [NUM_CPUS];
   logic              cur_idle_ff [NUM_CPUS];
   logic [TW-1:0]     scan_ptr_ff;
   logic [CW-1:0]     scan_left_ff;

   // Task table
   logic [1:0]        table_mem [MAX_TASKS];
   logic [1:0]        rd_data_ff;

   // Pending result and response register
   logic [CODE_W-1:0] res_code_ff;
   logic [TASK_W-1:0] res_tid_ff;
   logic              res_idle_ff;
   logic              rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic [TASK_W-1:0] rsp_tid_ff;
   logic              rsp_idle_ff;

   logic [CPU_W-1:0]  cpu_sel;
   logic              cpu_ok;
   logic [TW-1:0]     cur_idx;
   logic              cur_idle;
   logic [CW-1:0]     cur_inc;
   logic [CW-1:0]     scan_inc;
   logic [TW-1:0]     nxt_cur;
   logic [TW-1:0]     nxt_scan;
   logic [TW-1:0]     rd_addr;
   logic [TW-1:0]     wr_addr;

   // Select the issuing CPU's current task
   assign cpu_sel  = CPU_W'(cpu_ff);
   assign cpu_ok   = 32'(cpu_ff) < 32'(NUM_CPUS);
   assign cur_idx  = cur_idx_ff[cpu_sel];
   assign cur_idle = cur_idle_ff[cpu_sel];

   // Step circularly through the created tasks
   assign cur_inc  = CW'(cur_idx) + CW'(1);
   assign scan_inc = CW'(scan_ptr_ff) + CW'(1);
   assign nxt_cur  = (cur_inc == count_ff) ? '0 : TW'(cur_inc);
   assign nxt_scan = (scan_inc == count_ff) ? '0 : TW'(scan_inc);

   // Table address selection
   always_comb begin
      case (cmd.rd_src)
         RD_CUR:       rd_addr = cur_idx;
         RD_REQ:       rd_addr = TW'(treq_ff);
         RD_NEXT_CUR:  rd_addr = nxt_cur;
         RD_NEXT_SCAN: rd_addr = nxt_scan;
         default:      rd_addr = cur_idx;
      endcase
   end

   always_comb begin
      case (cmd.wr_dst)
         WR_COUNT: wr_addr = TW'(count_ff);
         WR_CUR:   wr_addr = cur_idx;
         WR_REQ:   wr_addr = TW'(treq_ff);
         WR_SCAN:  wr_addr = scan_ptr_ff;
         default:  wr_addr = cur_idx;
      endcase
   end

   // Task table with registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         table_mem[wr_addr] <= cmd.wr_val;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         cpu_ff  <= req_cpu;
         treq_ff <= req_task_req;
      end
   end

   // Task count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.cnt_inc) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // Per-CPU current task or idle mark
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            cur_idx_ff[c]  <= '0;
            cur_idle_ff[c] <= 1'b1;
         end
      end else if (cmd.cur_hit) begin
         cur_idx_ff[cpu_sel]  <= scan_ptr_ff;
         cur_idle_ff[cpu_sel] <= 1'b0;
      end else if (cmd.cur_idle) begin
         cur_idx_ff[cpu_sel]  <= '0;
         cur_idle_ff[cpu_sel] <= 1'b1;
      end
   end

   // Scan pointer tracks the entry whose state is in rd_data_ff
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ptr_ff  <= nxt_cur;
         scan_left_ff <= count_ff;
      end else if (cmd.scan_step) begin
         scan_ptr_ff  <= nxt_scan;
         scan_left_ff <= scan_left_ff - CW'(1);
      end
   end

   // Gather the result while the item is worked on
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_code_ff <= RES_OK;
         res_tid_ff  <= '0;
         res_idle_ff <= 1'b0;
      end else begin
         if (cmd.res_code_en) begin
            res_code_ff <= cmd.res_code;
         end
         if (cmd.res_tid_count) begin
            res_tid_ff <= TASK_W'(count_ff);
         end else if (cmd.res_tid_scan) begin
            res_tid_ff <= TASK_W'(scan_ptr_ff);
         end
         if (cmd.res_idle) begin
            res_idle_ff <= 1'b1;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_code_ff <= res_code_ff;
         rsp_tid_ff  <= res_tid_ff;
         rsp_idle_ff <= res_idle_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_task_id     = rsp_tid_ff;
   assign rsp_idle_chosen = rsp_idle_ff;

   // Status back to the controller
   assign status.op         = op_ff;
   assign status.cpu_ok     = cpu_ok;
   assign status.cur_live   = !cur_idle && (CW'(cur_idx) < count_ff);
   assign status.full       = count_ff >= CW'(MAX_TASKS);
   assign status.req_oob    = CMP_W'(treq_ff) >= CMP_W'(count_ff);
   assign status.count_zero = count_ff == '0;
   assign status.scan_last  = scan_left_ff == CW'(1);
   assign status.rd_state   = rd_data_ff;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

### rtl/rrts_ctrl.sv
// Controller state machine of the task scheduler.
`timescale 1ns / 1ps

module rrts_ctrl import rrts_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rrts_status_type status,
   output rrts_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SAVE = 3'd2;
   localparam logic [2:0] S_WAKE = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // Sequence one item at a time
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_RESP;
            case (status.op)
               OP_CREATE: begin
                  if (status.full) begin
                     cmd.res_code_en = 1'b1;
                     cmd.res_code    = RES_FULL;
                  end else begin
                     cmd.wr_en         = 1'b1;
                     cmd.wr_dst        = WR_COUNT;
                     cmd.wr_val        = ST_RUNNABLE;
                     cmd.res_tid_count = 1'b1;
                     cmd.cnt_inc       = 1'b1;
                  end
               end
               OP_SAVE: begin
                  if (status.cpu_ok && status.cur_live) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_src = RD_CUR;
                     state_in   = S_SAVE;
                  end
               end
               OP_SCHED: begin
                  if (status.cpu_ok) begin
                     if (status.count_zero) begin
                        cmd.cur_idle = 1'b1;
                        cmd.res_idle = 1'b1;
                     end else begin
                        cmd.scan_init = 1'b1;
                        cmd.rd_en     = 1'b1;
                        cmd.rd_src    = RD_NEXT_CUR;
                        state_in      = S_SCAN;
                     end
                  end
               end
               OP_BLOCK: begin
                  if (status.cpu_ok && status.cur_live) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_dst = WR_CUR;
                     cmd.wr_val = ST_BLOCKED;
                  end
               end
               OP_WAKE: begin
                  if (status.req_oob) begin
                     cmd.res_code_en = 1'b1;
                     cmd.res_code    = RES_NO_TASK;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_src = RD_REQ;
                     state_in   = S_WAKE;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // Release the current task unless it is blocked
         S_SAVE: begin
            if (status.rd_state != ST_BLOCKED) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_dst = WR_CUR;
               cmd.wr_val = ST_RUNNABLE;
            end
            state_in = S_RESP;
         end

         // Wake only a blocked task
         S_WAKE: begin
            if (status.rd_state == ST_BLOCKED) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_dst = WR_REQ;
               cmd.wr_val = ST_RUNNABLE;
            end
            state_in = S_RESP;
         end

         // Check one entry per cycle while the next read is issued
         S_SCAN: begin
            if (status.rd_state == ST_RUNNABLE) begin
               cmd.wr_en        = 1'b1;
               cmd.wr_dst       = WR_SCAN;
               cmd.wr_val       = ST_RUNNING;
               cmd.cur_hit      = 1'b1;
               cmd.res_tid_scan = 1'b1;
               state_in         = S_RESP;
            end else if (status.scan_last) begin
               cmd.cur_idle = 1'b1;
               cmd.res_idle = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.scan_step = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_src    = RD_NEXT_SCAN;
            end
         end

         // Hand the result over once the response register is free
         S_RESP: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/round_robin_task_scheduler.sv
// From accept to response valid: create, block, no-op and out-of-range wake go from the execute
// state to the response state; save of a live task and in-range wake add a table read; schedule
// scans from none to all of the created entries, one a cycle through the table's single read port.
// Throughput: one item at a time; the next is taken the cycle after the response loads.
// Synchronous reset clears the task count, marks every CPU idle and empties the response
// register; table contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module round_robin_task_scheduler import rrts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int NUM_CPUS  = NUM_CPUS_DEF
) (
   input logic       clock,
   input logic       reset,
   rrts_req_if.sink  req_chan,
   rrts_rsp_if.source rsp_chan
);

   rrts_cmd_type    cmd;
   rrts_status_type status;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrts_datapath #(
      .MAX_TASKS (MAX_TASKS),
      .NUM_CPUS  (NUM_CPUS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_chan.op),
      .req_cpu         (req_chan.cpu),
      .req_task_req    (req_chan.task_req),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_result_code (rsp_chan.result_code),
      .rsp_task_id     (rsp_chan.task_id),
      .rsp_idle_chosen (rsp_chan.idle_chosen)
   );

endmodule

### bench/tb_top.sv
// Self-checking testbench for the round-robin task scheduler against a table predictor.
`timescale 1ns / 1ps

module tb_top;
   import rrts_pkg::*;

   localparam int N_TASKS = MAX_TASKS_DEF;
   localparam int N_CPUS  = NUM_CPUS_DEF;

   // Operation codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   // Long receiver hold-off, once the sender is well into the last phase
   localparam int HOLD_AT  = 1500;
   localparam int HOLD_LEN = 400;

   // Settle time after the last response: longest scan plus margin
   localparam int DRAIN_CYCLES = N_TASKS + 64;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CPU_FW-1:0] cpu;
      logic [TASK_W-1:0] task_req;
   } sched_op_type;

   typedef struct packed {
      logic [CODE_W-1:0] result_code;
      logic [TASK_W-1:0] task_id;
      logic              idle_chosen;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrts_req_if req_chan ();
   rrts_rsp_if rsp_chan ();

   round_robin_task_scheduler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted task table and per-CPU state
   logic [1:0]        task_tbl [N_TASKS];
   int                tasks_live;
   logic [TASK_W-1:0] cpu_cur  [N_CPUS];
   logic              cpu_idle [N_CPUS];

   sched_op_type  op_backlog [$];
   sched_rsp_type rsp_due [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int n_accepted    = 0;
   int n_errors      = 0;
   int tasks_made    = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   // Apply one operation to the predicted table and return the expected response
   function automatic sched_rsp_type run_table_op(sched_op_type it);
      sched_rsp_type r;
      int            idx;
      bit            found;
      r     = '0;
      found = 1'b0;
      if (it.op == OP_CREATE) begin
         if (tasks_live >= N_TASKS) begin
            r.result_code = RES_FULL;
         end else begin
            task_tbl[tasks_live] = ST_RUNNABLE;
            r.task_id = TASK_W'(tasks_live);
            tasks_live++;
         end
      end else if (it.op == OP_SAVE && it.cpu < N_CPUS) begin
         if (!cpu_idle[it.cpu] && cpu_cur[it.cpu] < tasks_live)
            if (task_tbl[cpu_cur[it.cpu]] != ST_BLOCKED)
               task_tbl[cpu_cur[it.cpu]] = ST_RUNNABLE;
      end else if (it.op == OP_SCHED && it.cpu < N_CPUS) begin
         // walk circularly from the entry after the current one
         idx = cpu_cur[it.cpu];
         for (int i = 0; i < tasks_live && !found; i++) begin
            idx = (idx + 1) % tasks_live;
            if (task_tbl[idx] == ST_RUNNABLE) found = 1'b1;
         end
         if (found) begin
            task_tbl[idx]     = ST_RUNNING;
            cpu_cur[it.cpu]   = TASK_W'(idx);
            cpu_idle[it.cpu]  = 1'b0;
            r.task_id         = TASK_W'(idx);
         end else begin
            cpu_cur[it.cpu]   = '0;
            cpu_idle[it.cpu]  = 1'b1;
            r.idle_chosen     = 1'b1;
         end
      end else if (it.op == OP_BLOCK && it.cpu < N_CPUS) begin
         if (!cpu_idle[it.cpu] && cpu_cur[it.cpu] < tasks_live)
            task_tbl[cpu_cur[it.cpu]] = ST_BLOCKED;
      end else if (it.op == OP_WAKE) begin
         if (it.task_req >= tasks_live)
            r.result_code = RES_NO_TASK;
         else if (task_tbl[it.task_req] == ST_BLOCKED)
            task_tbl[it.task_req] = ST_RUNNABLE;
      end
      return r;
   endfunction

   task automatic push_op(logic [OP_W-1:0] op, logic [CPU_FW-1:0] cpu,
                          logic [TASK_W-1:0] task_req);
      sched_op_type it;
      it.op       = op;
      it.cpu      = cpu;
      it.task_req = task_req;
      op_backlog.push_back(it);
      if (op == OP_CREATE && tasks_made < N_TASKS) tasks_made++;
   endtask

   // Mostly context switches and wakes of live tasks, with some noise
   task automatic queue_random_ops(int n);
      int               pick;
      logic [CPU_FW-1:0] c;
      logic [TASK_W-1:0] t;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         c    = CPU_FW'($urandom_range(0, N_CPUS - 1));
         t    = TASK_W'($urandom);
         if (tasks_made > 0 && $urandom_range(0, 99) < 85)
            t = TASK_W'($urandom_range(0, tasks_made - 1));
         if (pick < 12) begin
            push_op(OP_CREATE, c, t);
         end else if (pick < 40) begin
            push_op(OP_SAVE, c, t);
            push_op(OP_SCHED, c, TASK_W'($urandom));
         end else if (pick < 52) begin
            push_op(OP_SAVE, c, t);
         end else if (pick < 66) begin
            push_op(OP_SCHED, c, t);
         end else if (pick < 77) begin
            push_op(OP_BLOCK, c, t);
         end else if (pick < 97) begin
            push_op(OP_WAKE, c, t);
         end else begin
            push_op(OP_SPARE_LO + OP_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO)),
                    c, t);
         end
      end
   endtask

   // Clock, period 4 ns
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Known values on every input before the first edge
   initial begin
      req_chan.valid    = 1'b0;
      req_chan.op       = '0;
      req_chan.cpu      = '0;
      req_chan.task_req = '0;
      rsp_chan.ready    = 1'b0;
   end

   // Drive items from the backlog; predict each one as it is accepted
   always @(posedge clock) begin : drive
      sched_op_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            it.op       = req_chan.op;
            it.cpu      = req_chan.cpu;
            it.task_req = req_chan.task_req;
            rsp_due.push_back(run_table_op(it));
            n_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               it = op_backlog.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.op       <= it.op;
               req_chan.cpu      <= it.cpu;
               req_chan.task_req <= it.task_req;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Count out the long hold-off once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver ready: random stalls, forced low during the hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Check each accepted response against the oldest prediction
   always @(posedge clock) begin : check
      sched_rsp_type exp_rsp;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_due.size() == 0) begin
            $error("response with nothing outstanding: code %0d task %0d idle %0b",
                   rsp_chan.result_code, rsp_chan.task_id, rsp_chan.idle_chosen);
            n_errors++;
         end else begin
            exp_rsp = rsp_due.pop_front();
            if (rsp_chan.result_code !== exp_rsp.result_code) begin
               $error("result_code: expected %0d, got %0d",
                      exp_rsp.result_code, rsp_chan.result_code);
               n_errors++;
            end
            if (rsp_chan.task_id !== exp_rsp.task_id) begin
               $error("task_id: expected %0d, got %0d", exp_rsp.task_id, rsp_chan.task_id);
               n_errors++;
            end
            if (rsp_chan.idle_chosen !== exp_rsp.idle_chosen) begin
               $error("idle_chosen: expected %0b, got %0b",
                      exp_rsp.idle_chosen, rsp_chan.idle_chosen);
               n_errors++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      tasks_live = 0;
      for (int c = 0; c < N_CPUS; c++) begin
         cpu_cur[c]  = '0;
         cpu_idle[c] = 1'b1;
      end
      send_idle_pct = 26;
      recv_idle_pct = 65;

      // empty table, idle CPUs, wake past the count, spare opcodes
      push_op(OP_SCHED, 3'd0, 8'd0);
      push_op(OP_SAVE,  3'd1, 8'd0);
      push_op(OP_BLOCK, 3'd2, 8'd0);
      push_op(OP_WAKE,  3'd0, 8'd0);
      for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++)
         push_op(OP_W'(o), 3'd7, 8'd255);
      push_op(OP_CREATE, 3'd0, 8'd0);
      push_op(OP_CREATE, 3'd7, 8'd255);
      push_op(OP_CREATE, 3'd3, 8'd0);
      // idle start picks task 1, then 2, then wraps to 0
      push_op(OP_SCHED, 3'd0, 8'd0);
      push_op(OP_SCHED, 3'd7, 8'd0);
      push_op(OP_SCHED, 3'd3, 8'd0);
      // nothing runnable: previous task left running, CPU goes idle
      push_op(OP_SCHED, 3'd3, 8'd0);
      // current task still runnable gets picked again
      push_op(OP_SAVE,  3'd0, 8'd0);
      push_op(OP_SCHED, 3'd0, 8'd0);
      // block, save keeps it blocked, wake of running and of blocked
      push_op(OP_BLOCK, 3'd0, 8'd0);
      push_op(OP_SAVE,  3'd0, 8'd0);
      push_op(OP_WAKE,  3'd5, 8'd2);
      push_op(OP_WAKE,  3'd5, 8'd1);
      push_op(OP_WAKE,  3'd2, 8'd255);
      push_op(OP_SCHED, 3'd7, 8'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      queue_random_ops(460);
      wait (op_backlog.size() == 0);
      send_idle_pct = 65;
      recv_idle_pct = 26;

      queue_random_ops(460);
      wait (op_backlog.size() == 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;

      queue_random_ops(380);
      // fill the table, overrun it, then work on a full table
      while (tasks_made < N_TASKS) push_op(OP_CREATE, CPU_FW'($urandom), TASK_W'($urandom));
      for (int k = 0; k < 3; k++) push_op(OP_CREATE, CPU_FW'($urandom), TASK_W'($urandom));
      queue_random_ops(45);

      wait (op_backlog.size() == 0 && !req_chan.valid);
      wait (rsp_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_errors == 0 && rsp_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
